[rtl/strict_decimal_integer_parser_unit_macros.svh]
// Assertion helpers shared by the checkers of the decimal parser.
`ifndef STRICT_DECIMAL_INTEGER_PARSER_UNIT_MACROS_SVH
`define STRICT_DECIMAL_INTEGER_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define SDIP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdip check failed");

// Next-cycle implication, held off during reset.
`define SDIP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdip check failed");

`endif

[rtl/sdip_pkg.sv]
`timescale 1ns / 1ps
package sdip_pkg;

  localparam int unsigned ValueWidth  = 64;
  localparam int unsigned SymbolWidth = 8;

  localparam logic [SymbolWidth-1:0] SymNul   = 8'h00;
  localparam logic [SymbolWidth-1:0] SymMinus = 8'h2D;
  localparam logic [SymbolWidth-1:0] SymZero  = 8'h30;
  localparam logic [SymbolWidth-1:0] SymNine  = 8'h39;

  // Largest magnitude that may still take a digit: floor((2^64-1) / 10)
  localparam logic [ValueWidth-1:0] MagDiv10   = 64'h1999_9999_9999_9999;
  localparam logic [3:0]            MagLastDig = 4'd5;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_FORMAT = 2'd1,
    STATUS_OVERFLOW   = 2'd2
  } status_t;

  // Final parse state of one string, decoded into a word on the way out
  typedef struct packed {
    logic                  mode;
    logic [ValueWidth-1:0] mag;
    logic                  ovf;
    logic                  neg;
    logic                  digits;
    logic                  bad;
  } res_t;

endpackage

[rtl/sdip_in_if.sv]
`timescale 1ns / 1ps
interface sdip_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] symbol;
  logic       has_symbol;
  logic       last;

  modport source (output valid, mode, symbol, has_symbol, last, input ready);
  modport sink   (input valid, mode, symbol, has_symbol, last, output ready);
endinterface

[rtl/sdip_out_if.sv]
`timescale 1ns / 1ps
interface sdip_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [1:0]  status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

[rtl/strict_decimal_integer_parser_unit.sv]
`timescale 1ns / 1ps
// Strict decimal integer parser: takes one byte of a string per cycle on item
// and, on the word marked last, returns the 64-bit value and a status on result
// (0 ok, 1 invalid format, 2 overflow; value is 0 on error). The string is an
// optional leading minus and one or more digits; a zero byte ends it early.
// mode on the last word picks signed (0) or unsigned (1) range. Throughput is
// one byte per cycle with no gaps between strings while item.ready is high;
// the accumulator step (times ten as shift-and-add, plus the digit, with its
// overflow compare) is the one path that sets this. A result is registered
// into a two-entry output buffer when its last byte is accepted; input runs on
// while a result waits, and item.ready drops only when both entries are full.
module strict_decimal_integer_parser_unit (
  input logic       clk,
  input logic       rst,
  sdip_in_if.sink   item,
  sdip_out_if.source result
);
  import sdip_pkg::*;

  // Accumulator state
  logic [ValueWidth-1:0] mag, mag_next;
  logic ovf, ovf_next;
  logic neg, neg_next;
  logic digits, digits_next;
  logic bad, bad_next;
  logic term, term_next;
  logic pos, pos_next;

  // Output buffer: head entry and skid entry
  res_t res_head, res_skid, res_new;
  logic head_valid, skid_valid;

  logic                  accept;
  logic                  push;
  logic                  pop;
  logic [3:0]            dig;
  logic                  is_digit;
  logic                  dig_ovf;
  logic [ValueWidth-1:0] mag_x10;
  status_t               out_status;
  logic [ValueWidth-1:0] out_value;

  assign item.ready = !skid_valid;
  assign accept     = item.valid && item.ready;
  assign push       = accept && item.last;
  assign pop        = head_valid && result.ready;

  // Take one byte into the accumulator
  always_comb begin
    digits_next = digits;
    mag_next    = mag;
    ovf_next    = ovf;
    neg_next    = neg;
    bad_next    = bad;
    term_next   = term;
    pos_next    = pos;
    is_digit    = (item.symbol >= SymZero) && (item.symbol <= SymNine);
    dig         = 4'(item.symbol - SymZero);
    mag_x10     = (mag << 3) + (mag << 1);
    dig_ovf     = (mag > MagDiv10) || ((mag == MagDiv10) && (dig > MagLastDig));
    if (item.has_symbol && !term) begin
      if (item.symbol == SymNul) begin
        term_next = 1'b1;
      end else begin
        pos_next = 1'b1;
        if (is_digit) begin
          digits_next = 1'b1;
          if (!ovf) begin
            if (dig_ovf) begin
              ovf_next = 1'b1;
            end else begin
              mag_next = mag_x10 + {{(ValueWidth-4){1'b0}}, dig};
            end
          end
        end else if ((item.symbol == SymMinus) && !pos) begin
          neg_next = 1'b1;
        end else begin
          bad_next = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_new.mode   = item.mode;
    res_new.mag    = mag_next;
    res_new.ovf    = ovf_next;
    res_new.neg    = neg_next;
    res_new.digits = digits_next;
    res_new.bad    = bad_next;
  end

  // Advance the accumulator; clear it after the last byte of a string
  always_ff @(posedge clk) begin
    if (rst || push) begin
      mag    <= '0;
      ovf    <= 1'b0;
      neg    <= 1'b0;
      digits <= 1'b0;
      bad    <= 1'b0;
      term   <= 1'b0;
      pos    <= 1'b0;
    end else if (accept) begin
      mag    <= mag_next;
      ovf    <= ovf_next;
      neg    <= neg_next;
      digits <= digits_next;
      bad    <= bad_next;
      term   <= term_next;
      pos    <= pos_next;
    end
  end

  // Hold finished words in head, spill into skid while head is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        res_head   <= res_skid;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!head_valid || pop) begin
        res_head   <= res_new;
        head_valid <= 1'b1;
      end else begin
        res_skid   <= res_new;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      head_valid <= 1'b0;
    end
  end

  // Decode the head entry into status and value
  always_comb begin
    out_status = STATUS_OK;
    out_value  = '0;
    if (res_head.bad || !res_head.digits) begin
      out_status = STATUS_BAD_FORMAT;
    end else if (res_head.mode) begin
      if (res_head.neg || res_head.ovf) begin
        out_status = STATUS_OVERFLOW;
      end else begin
        out_value = res_head.mag;
      end
    end else if (res_head.ovf) begin
      out_status = STATUS_OVERFLOW;
    end else if (res_head.neg) begin
      // Negative side reaches down to minus 2^63
      if (res_head.mag[ValueWidth-1] && (|res_head.mag[ValueWidth-2:0])) begin
        out_status = STATUS_OVERFLOW;
      end else begin
        out_value = '0 - res_head.mag;
      end
    end else if (res_head.mag[ValueWidth-1]) begin
      out_status = STATUS_OVERFLOW;
    end else begin
      out_value = res_head.mag;
    end
  end

  assign result.valid  = head_valid;
  assign result.value  = out_value;
  assign result.status = out_status;

endmodule

[rtl/sdip_checker.sv]
`timescale 1ns / 1ps
`include "strict_decimal_integer_parser_unit_macros.svh"
module sdip_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_value,
  input logic [1:0]  out_status
);
  import sdip_pkg::*;

  // Only the three defined codes leave the block
  `SDIP_ASSERT_SAME(a_status_code, out_valid,
                    (out_status == STATUS_OK) || (out_status == STATUS_BAD_FORMAT) ||
                    (out_status == STATUS_OVERFLOW))

  // An error word carries a zero value
  `SDIP_ASSERT_SAME(a_err_zero, out_valid && (out_status != STATUS_OK), out_value == '0)

  // No word appears right after reset
  `SDIP_ASSERT_SAME(a_reset_empty, $past(rst), !out_valid)

  // A stalled word holds
  `SDIP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_value) && $stable(out_status))

endmodule

bind strict_decimal_integer_parser_unit sdip_checker u_sdip_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_value  (result.value),
  .out_status (result.status)
);

[tb/sv/sdip_tb_pkg.sv]
`timescale 1ns / 1ps
package sdip_tb_pkg;
  import sdip_pkg::*;

  localparam logic MODE_SIGNED   = 1'b0;
  localparam logic MODE_UNSIGNED = 1'b1;

  // Largest positive signed magnitude is this minus one
  localparam logic [63:0] SignedLimit = 64'h8000_0000_0000_0000;

  class int_parse_scoreboard;
    typedef struct packed {
      logic [63:0] value;
      status_t     status;
    } parse_result_t;

    parse_result_t expected_parses[$];

    // Running parse state of the string in flight
    logic [63:0] mag;
    bit          mag_ovf;
    bit          neg;
    bit          digits;
    bit          bad;
    bit          ended;
    bit          started;

    int unsigned mismatches;
    int unsigned strings_checked;
    int unsigned status_count[3];

    function new();
      clear();
      mismatches      = 0;
      strings_checked = 0;
      status_count    = '{0, 0, 0};
    endfunction

    function void clear();
      mag     = '0;
      mag_ovf = 0;
      neg     = 0;
      digits  = 0;
      bad     = 0;
      ended   = 0;
      started = 0;
    endfunction

    function int pending();
      return expected_parses.size();
    endfunction

    // Fold one accepted word into the parse; queue a result on the last word
    function void note_word(logic m, logic [7:0] s, logic h, logic l);
      logic [63:0]   d;
      parse_result_t r;
      if (h && !ended) begin
        if (s == SymNul) begin
          ended = 1;
        end else begin
          if (s >= SymZero && s <= SymNine) begin
            d      = 64'(s - SymZero);
            digits = 1;
            if (!mag_ovf) begin
              if (mag > MagDiv10 || (mag == MagDiv10 && d > 64'(MagLastDig)))
                mag_ovf = 1;
              else
                mag = mag * 64'd10 + d;
            end
          end else if (s == SymMinus && !started) begin
            neg = 1;
          end else begin
            bad = 1;
          end
          started = 1;
        end
      end
      if (!l) return;

      // Decide status: format first, then range for the selected mode
      r.value  = '0;
      r.status = STATUS_OK;
      if (bad || !digits) begin
        r.status = STATUS_BAD_FORMAT;
      end else if (m == MODE_UNSIGNED) begin
        if (neg || mag_ovf) r.status = STATUS_OVERFLOW;
        else r.value = mag;
      end else if (mag_ovf) begin
        r.status = STATUS_OVERFLOW;
      end else if (neg) begin
        if (mag > SignedLimit) r.status = STATUS_OVERFLOW;
        else r.value = 64'd0 - mag;
      end else if (mag > SignedLimit - 64'd1) begin
        r.status = STATUS_OVERFLOW;
      end else begin
        r.value = mag;
      end
      expected_parses.push_back(r);
      clear();
    endfunction

    // Compare one delivered result against the oldest queued parse
    function void check_result(logic [63:0] value, logic [1:0] status);
      parse_result_t e;
      if (expected_parses.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: value %0d status %0d", value, status);
        mismatches++;
        return;
      end
      e = expected_parses.pop_front();
      strings_checked++;
      status_count[int'(e.status)]++;
      if (e.status != status || e.value != value) begin
        if (mismatches < 10)
          $display("result mismatch: expected value %0d status %0d, got value %0d status %0d",
                   e.value, e.status, value, status);
        mismatches++;
      end
    endfunction
  endclass

endpackage

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import sdip_pkg::*;
  import sdip_tb_pkg::*;

  typedef logic [7:0] text_t[$];

  logic clk;
  logic rst;
  bit   calm;
  int unsigned words_counted;

  sdip_in_if  item ();
  sdip_out_if result ();

  strict_decimal_integer_parser_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result)
  );

  int_parse_scoreboard parses = new();

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // Mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Present one word, wait for acceptance, and record it
  task automatic send_word(logic m, logic [7:0] s, logic h, logic l);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      item.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.valid      <= 1'b1;
    item.mode       <= m;
    item.symbol     <= s;
    item.has_symbol <= h;
    item.last       <= l;
    do @(posedge clk); while (!item.ready);
    parses.note_word(m, s, h, l);
    if (h || l) words_counted++;
  endtask

  // Send a byte string; blanks inserts empty words, possibly as the last word
  task automatic send_string(text_t bytes, logic m, bit blanks);
    bit tail_blank;
    bit is_last;
    tail_blank = (bytes.size() == 0) || (blanks && $urandom_range(2) == 0);
    foreach (bytes[i]) begin
      if (blanks && $urandom_range(3) == 0)
        send_word(1'($urandom), 8'($urandom), 1'b0, 1'b0);
      is_last = (i == bytes.size() - 1) && !tail_blank;
      send_word(is_last ? m : 1'($urandom), bytes[i], 1'b1, is_last);
    end
    if (tail_blank) send_word(m, 8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic text_t to_bytes(string s);
    text_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(8'(s[i]));
    return q;
  endfunction

  // Hold the sender until every queued parse has come back
  task automatic drain();
    item.valid <= 1'b0;
    while (parses.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Build one random string: mostly well formed, some terminated early, some noise
  task automatic random_string();
    string       edges[5];
    text_t       q;
    int unsigned kind;
    int unsigned len;
    int unsigned r;
    edges = '{"9223372036854775807", "9223372036854775808", "18446744073709551615",
              "18446744073709551616", "1844674407370955161"};
    kind = $urandom_range(99);
    if (kind < 85) begin
      if ($urandom_range(9) < 3) q.push_back(SymMinus);
      r = $urandom_range(99);
      if (r < 20) begin
        // near a range edge: tweak the trailing digits
        q = {q, to_bytes(edges[$urandom_range(4)])};
        for (int k = 1; k <= 2; k++)
          if ($urandom_range(1) == 1) q[q.size() - k] = SymZero + 8'($urandom_range(9));
      end else begin
        if (r < 60) len = $urandom_range(6, 1);
        else if (r < 90) len = $urandom_range(18, 7);
        else len = $urandom_range(22, 19);
        repeat (len) q.push_back(SymZero + 8'($urandom_range(9)));
      end
      if (kind >= 70) begin
        q.push_back(SymNul);
        repeat ($urandom_range(3)) q.push_back(8'($urandom));
      end
    end else begin
      len = $urandom_range(6);
      repeat (len) begin
        r = $urandom_range(2);
        if (r == 0) q.push_back(SymZero + 8'($urandom_range(9)));
        else if (r == 1) q.push_back(SymMinus);
        else q.push_back(8'($urandom));
      end
    end
    send_string(q, 1'($urandom), $urandom_range(9) == 0);
  endtask

  // Sink side: check accepted results, stall ready at random
  initial begin
    int unsigned stall;
    stall        = 0;
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result.valid && result.ready)
        parses.check_result(result.value, result.status);
      if (stall != 0) begin
        stall--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    int unsigned strings_sent;
    text_t       no_bytes;
    item.valid      = 1'b0;
    item.mode       = MODE_SIGNED;
    item.symbol     = '0;
    item.has_symbol = 1'b0;
    item.last       = 1'b0;
    rst             = 1'b1;
    calm            = 1'b0;
    words_counted   = 0;
    strings_sent    = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: range edges, sign rules, early termination, format errors
    send_string(to_bytes("0"), MODE_SIGNED, 0);
    send_string(to_bytes("-0"), MODE_SIGNED, 0);
    send_string(to_bytes("-0"), MODE_UNSIGNED, 0);
    send_string(to_bytes("9223372036854775807"), MODE_SIGNED, 0);
    send_string(to_bytes("9223372036854775808"), MODE_SIGNED, 0);
    send_string(to_bytes("-9223372036854775808"), MODE_SIGNED, 0);
    send_string(to_bytes("-9223372036854775809"), MODE_SIGNED, 0);
    send_string(to_bytes("18446744073709551615"), MODE_UNSIGNED, 0);
    send_string(to_bytes("18446744073709551616"), MODE_UNSIGNED, 0);
    send_string(to_bytes("99999999999999999999"), MODE_SIGNED, 0);
    send_string(to_bytes("-5"), MODE_UNSIGNED, 0);
    send_string(to_bytes("-"), MODE_SIGNED, 0);
    send_string(no_bytes, MODE_UNSIGNED, 0);
    send_string('{SymNul, 8'h37}, MODE_SIGNED, 0);
    send_string('{8'h31, 8'h32, SymNul, 8'hFF, SymMinus}, MODE_UNSIGNED, 0);
    send_string(to_bytes("1-2"), MODE_SIGNED, 0);
    send_string(to_bytes("--1"), MODE_SIGNED, 0);
    send_string('{8'h39, 8'hC6, 8'h39}, MODE_UNSIGNED, 0);
    send_string(to_bytes("9x99999999999999999999"), MODE_UNSIGNED, 0);
    send_string(to_bytes("42"), MODE_SIGNED, 1);
    drain();

    // Random strings, with quiet stretches and forced drains
    words_counted = 0;
    while (words_counted < 1950) begin
      if (strings_sent % 40 == 0) calm = ($urandom_range(3) == 0);
      if (strings_sent == 150 || strings_sent == 300) drain();
      random_string();
      strings_sent++;
    end
    calm = 1'b0;

    item.valid <= 1'b0;
    while (parses.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("checked %0d parses: %0d ok, %0d bad format, %0d overflow",
             parses.strings_checked, parses.status_count[0], parses.status_count[1],
             parses.status_count[2]);
    $display("mismatches: %0d", parses.mismatches);
    if (parses.mismatches == 0 && parses.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/sdip_pkg.sv
rtl/sdip_in_if.sv
rtl/sdip_out_if.sv
rtl/strict_decimal_integer_parser_unit.sv
rtl/sdip_checker.sv
tb/sv/sdip_tb_pkg.sv
tb/sv/testbench.sv
